FILE: design/sita_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package sita_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW     = $clog2(MaxDigits + 1);

  // Divide by ten as multiply by reciprocal: q = (x * RECIP) >> RecipShift,
  // exact for every 32-bit unsigned x.
  localparam logic [ValueW-1:0] Recip      = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;
  localparam int unsigned       ProdW      = 2 * ValueW;
  localparam int unsigned       QuotW      = ProdW - RecipShift;

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StSign,
    StEmit
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic pop;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic quot_zero;
    logic neg;
    logic last_digit;
  } status_t;

endpackage

`default_nettype wire

FILE: design/sita_datapath.sv
// Datapath: magnitude, divide-by-ten step, digit stack and character output.
`timescale 1ns / 1ps
`default_nettype none

module sita_datapath
  import sita_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ValueW-1:0] value_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic [CharW-1:0]       char_code_o,
  output logic                   last_char_o
);

  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [ProdW-1:0]  prod_q;
  logic [DigitW-1:0] stack_q [MaxDigits];
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] quot_x10;
  logic [ValueW-1:0] rem_full;
  logic [DigitW-1:0] digit;

  // Quotient and remainder from the registered product
  always_comb begin
    quot     = prod_q[ProdW-1:RecipShift];
    quot_x10 = {{(ValueW-QuotW){1'b0}}, quot} * ValueW'(10);
    rem_full = mag_q - quot_x10;
    digit    = rem_full[DigitW-1:0];
  end

  // Magnitude, sign and digit count
  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      neg_d = value_i[ValueW-1];
      mag_d = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
      cnt_d = '0;
    end else if (cmd_i.div) begin
      mag_d = {{(ValueW-QuotW){1'b0}}, quot};
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  // Reciprocal multiply, registered before the remainder step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{ValueW{1'b0}}, mag_q} * {{ValueW{1'b0}}, Recip};
    end
  end

  // Digit stack: newest (most significant) digit sits at index 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      stack_q[0] <= digit;
      for (int i = 1; i < MaxDigits; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MaxDigits - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
      stack_q[MaxDigits-1] <= '0;
    end
  end

  // Status and character output
  always_comb begin
    status_o.quot_zero  = (quot == '0);
    status_o.neg        = neg_q;
    status_o.last_digit = (cnt_q == CntW'(1));
    char_code_o = cmd_i.emit_sign ? CharMinus
                                  : (CharZero + {{(CharW-DigitW){1'b0}}, stack_q[0]});
    last_char_o = cmd_i.pop && (cnt_q == CntW'(1));
  end

endmodule

`default_nettype wire

FILE: design/sita_ctrl.sv
// Controller: sequences load, divide steps and character emission.
`timescale 1ns / 1ps
`default_nettype none

module sita_ctrl
  import sita_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy_o,
  output logic         strobe_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (!status_i.quot_zero) begin
          state_d = StMul;
        end else if (status_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StEmit;
        end
      end
      StSign: begin
        cmd_o.emit_sign = 1'b1;
        strobe_o        = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        cmd_o.pop = 1'b1;
        strobe_o  = 1'b1;
        if (status_i.last_digit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// A transaction starts when start is high while busy is low. The value's decimal
// text then appears one character per strobe (char_valid_o), most significant
// first, with a leading '-' for negative values; last_char_o marks the final
// character. Results cannot be held off: each is present for one cycle only.
// Digits come from a divide-by-ten loop (registered reciprocal multiply, then
// remainder), each of the 1..10 digits passing through StMul then StDiv; the
// optional sign and the digits are then emitted, and busy drops the cycle
// after the last character.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii
  import sita_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   char_valid_o,
  output logic [CharW-1:0]       char_code_o,
  output logic                   last_char_o
);

  cmd_t    cmd;
  status_t status;

  sita_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (char_valid_o)
  );

  sita_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  // Characters only come out while a transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) char_valid_o |-> busy)
    else $error("character strobe while not busy");

  // The last flag only rides on a strobed character
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_char_o |-> char_valid_o)
    else $error("last_char without strobe");

  // After the last character the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_char_o |=> !busy)
    else $error("still busy after last character");

  // An accepted transaction produces no character in its first cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy) |=> (busy && !char_valid_o))
    else $error("accept did not start conversion");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb;
  import sita_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 450;
  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 40;

  localparam logic [CharW-1:0] MinusCode = 6'd45;
  localparam logic [CharW-1:0] ZeroCode  = 6'd48;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy;
  logic              char_valid_o;
  logic [CharW-1:0]  char_code_o;
  logic              last_char_o;

  // Characters still owed by the block, oldest first
  text_char_t pending_chars[$];
  int         errors      = 0;
  int         idle_cycles = 0;
  int         gap_max     = 7;

  // Directed values; an empty text means the expected characters come from the predictor
  logic [ValueW-1:0] dir_values [NumDirected] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    32'd1000000000, -32'sd1000000000, 32'd999999999,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd12345, -32'sd987654321,
    32'd100, 32'd1000000, -32'sd100
  };
  string dir_texts [NumDirected] = '{
    "0", "1", "-1", "9", "-9", "10", "-10",
    "2147483647", "-2147483648", "-2147483647",
    "1000000000", "-1000000000", "",
    "", "", "", "",
    "", "", ""
  };

  signed_int_to_decimal_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Decimal text of a two's complement value, queued most significant first
  function automatic void queue_decimal_text(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digits [MaxDigits];
    int                count;
    mag   = v[ValueW-1] ? -v : v;
    count = 0;
    do begin
      digits[count] = DigitW'(mag % 10);
      mag = mag / 10;
      count++;
    end while (mag != 0);
    if (v[ValueW-1]) begin
      pending_chars.push_back(text_char_t'{code: MinusCode, last: 1'b0});
    end
    for (int k = count - 1; k >= 0; k--) begin
      pending_chars.push_back(text_char_t'{code: ZeroCode + CharW'(digits[k]),
                                           last: (k == 0)});
    end
  endfunction

  // One transaction: optional hold-off, then start held until the block takes it
  task automatic send_value(input logic [ValueW-1:0] v, input string text);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (text.len() == 0) begin
      queue_decimal_text(v);
    end else begin
      for (int k = 0; k < text.len(); k++) begin
        pending_chars.push_back(text_char_t'{code: CharW'(text[k]),
                                             last: (k == text.len() - 1)});
      end
    end
  endtask

  // Result checker: every strobe is matched against the oldest owed character
  always @(posedge clk_i) begin : check_chars
    text_char_t got;
    text_char_t want;
    if (rst_ni) begin
      if ($isunknown(char_valid_o)) begin
        $display("%0t: char_valid_o expected 0 or 1, got %b", $time, char_valid_o);
        errors++;
      end else if (char_valid_o) begin
        got = text_char_t'{code: char_code_o, last: last_char_o};
        if (pending_chars.size() == 0) begin
          $display("%0t: char expected none, got code %0d last %b",
                   $time, got.code, got.last);
          errors++;
        end else begin
          want = pending_chars.pop_front();
          if (got.code !== want.code) begin
            $display("%0t: char_code expected %0d, got %0d", $time, want.code, got.code);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_char expected %b, got %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long without an accepted value or character
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || char_valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    logic [ValueW-1:0] v;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_value(dir_values[i], dir_texts[i]);
    end

    // Random part: mostly values of a chosen digit count, some raw 32-bit patterns
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0) begin
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      end
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom();
      end else begin
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = (n == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (n == 1) lo = 0;
        mag = $urandom_range(hi, lo);
        v   = $urandom_range(0, 1) ? -mag : mag;
      end
      send_value(v, "");
    end
    start <= 1'b0;

    // Drain, then watch a while longer for stray characters
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sita_pkg.sv
design/sita_datapath.sv
design/sita_ctrl.sv
design/signed_int_to_decimal_ascii.sv
dv/tb.sv
